// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Field widths, request and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRIO_W = 3;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;

    localparam int DEF_CAPACITY        = 16;
    localparam int DEF_PRIORITY_LEVELS = 7;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } spq_cmd_t;

endpackage

// File: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in ascending priority order
// Inserts go in front of the first entry of equal or higher priority value;
// removes take the head. One result beat is produced for every request.
// ----------------------------------------------------------------------------
// Latency: the result beat is on the ports in the cycle after the request is
// accepted, marked by done for exactly one cycle; the receiver cannot stall.
// Pacing: a new request is not accepted while busy; busy is high during the
// result cycle, set by the two-state request controller.
// Reset: rst_n (asynchronous, active low) empties the queue and clears the
// controller; stored slots and result registers are not reset.
module sorted_priority_queue
#(
    parameter int CAPACITY        = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_LEVELS = spq_pkg::DEF_PRIORITY_LEVELS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    output logic                       done,
    input  logic                       req_type,
    input  logic [spq_pkg::PRIO_W-1:0] priority_req,
    input  logic [spq_pkg::TAG_W-1:0]  message_tag,
    output logic                       entry_valid,
    output logic [spq_pkg::PRIO_W-1:0] entry_priority,
    output logic [spq_pkg::TAG_W-1:0]  entry_tag,
    output logic [spq_pkg::STAT_W-1:0] status,
    output logic                       is_empty
);
    import spq_pkg::*;

    // The controller turns an accepted request into a one-cycle execute
    // command; the datapath updates the whole sorted array at that edge and
    // registers the result, which the controller then flags with done.
    spq_cmd_t cmd;

    spq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    spq_datapath
    #(
        .CAPACITY        (CAPACITY),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req_type       (req_type),
        .priority_req   (priority_req),
        .message_tag    (message_tag),
        .entry_valid    (entry_valid),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .status         (status),
        .is_empty       (is_empty)
    );

    // Every accepted request yields its result beat in the next cycle.
    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request produced no result beat");

    // A result beat lasts a single cycle.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held for more than one cycle");

    // A delivered entry always comes with ok status (entries come only from removals).
    a_valid_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && entry_valid) |-> (status == ST_OK))
        else $error("entry delivered with error status");

    // A removal from an empty queue leaves it empty.
    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (is_empty && !entry_valid))
        else $error("empty removal reported inconsistent state");

endmodule

// File: hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: request controller
// Accepts a request, tells the datapath to execute it, then presents the
// result beat for one cycle while holding off the next request.
// ----------------------------------------------------------------------------
module spq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg == ST_RESP);
    assign done     = (state_reg == ST_RESP);
    assign cmd.exec = (state_reg == ST_IDLE) && start;

endmodule

// File: hw/rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath: sorted shift-register array
// Every slot compares its priority with the incoming one and chooses to
// hold, take the new entry, or shift, all together in the same update.
// ----------------------------------------------------------------------------
module spq_datapath
#(
    parameter int CAPACITY        = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_LEVELS = spq_pkg::DEF_PRIORITY_LEVELS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spq_pkg::spq_cmd_t          cmd,
    input  logic                       req_type,
    input  logic [spq_pkg::PRIO_W-1:0] priority_req,
    input  logic [spq_pkg::TAG_W-1:0]  message_tag,
    output logic                       entry_valid,
    output logic [spq_pkg::PRIO_W-1:0] entry_priority,
    output logic [spq_pkg::TAG_W-1:0]  entry_tag,
    output logic [spq_pkg::STAT_W-1:0] status,
    output logic                       is_empty
);
    import spq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [PRIO_W-1:0] prio_reg [CAPACITY];
    logic [TAG_W-1:0]  tag_reg  [CAPACITY];
    logic [PRIO_W-1:0] prio_next [CAPACITY];
    logic [TAG_W-1:0]  tag_next  [CAPACITY];
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    logic              full;
    logic              empty;
    logic [PRIO_W-1:0] prio_clamped;
    logic [CAPACITY-1:0] at_or_after;
    logic              do_insert;
    logic              do_remove;

    logic              valid_reg;
    logic [PRIO_W-1:0] eprio_reg;
    logic [TAG_W-1:0]  etag_reg;
    logic [STAT_W-1:0] status_reg;
    logic              empty_reg;

    logic              valid_next;
    logic [PRIO_W-1:0] eprio_next;
    logic [TAG_W-1:0]  etag_next;
    logic [STAT_W-1:0] status_next;

    assign full  = (occ_reg == OCC_W'(CAPACITY));
    assign empty = (occ_reg == '0);

    always_comb
    begin
        if (int'(priority_req) > PRIORITY_LEVELS - 1)
        begin
            prio_clamped = PRIO_W'(PRIORITY_LEVELS - 1);
        end
        else
        begin
            prio_clamped = priority_req;
        end
    end

    assign do_insert = cmd.exec && (req_type == REQ_INSERT) && !full;
    assign do_remove = cmd.exec && (req_type == REQ_REMOVE) && !empty;

    // The array is sorted, so the slots at or past the insert point form a
    // contiguous upper run; unused slots always belong to it.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_slot
            assign at_or_after[gi] = (occ_reg <= OCC_W'(gi)) || (prio_reg[gi] >= prio_clamped);

            always_comb
            begin
                prio_next[gi] = prio_reg[gi];
                tag_next[gi]  = tag_reg[gi];
                if (do_insert && at_or_after[gi])
                begin
                    if (gi == 0 || !at_or_after[(gi == 0) ? 0 : gi - 1])
                    begin
                        prio_next[gi] = prio_clamped;
                        tag_next[gi]  = message_tag;
                    end
                    else
                    begin
                        prio_next[gi] = prio_reg[(gi == 0) ? 0 : gi - 1];
                        tag_next[gi]  = tag_reg[(gi == 0) ? 0 : gi - 1];
                    end
                end
                else if (do_remove && gi < CAPACITY - 1)
                begin
                    prio_next[gi] = prio_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    tag_next[gi]  = tag_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge clk)
            begin
                prio_reg[gi] <= prio_next[gi];
                tag_reg[gi]  <= tag_next[gi];
            end
        end
    endgenerate

    always_comb
    begin
        occ_next    = occ_reg;
        valid_next  = 1'b0;
        eprio_next  = '0;
        etag_next   = '0;
        status_next = ST_OK;
        if (req_type == REQ_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                valid_next = 1'b1;
                eprio_next = prio_reg[0];
                etag_next  = tag_reg[0];
                occ_next   = occ_reg - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.exec)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            valid_reg  <= valid_next;
            eprio_reg  <= eprio_next;
            etag_reg   <= etag_next;
            status_reg <= status_next;
            empty_reg  <= (occ_next == '0);
        end
    end

    assign entry_valid    = valid_reg;
    assign entry_priority = eprio_reg;
    assign entry_tag      = etag_reg;
    assign status         = status_reg;
    assign is_empty       = empty_reg;

endmodule

// File: test/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: watches the request and result channels of the priority queue
// Keeps a shadow copy of the sorted slots, forecasts the result beat of each
// accepted request and compares every result beat against the oldest forecast.
// ----------------------------------------------------------------------------
module spq_checker
#(
    parameter int CAPACITY        = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_LEVELS = spq_pkg::DEF_PRIORITY_LEVELS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       done,
    input  logic                       req_type,
    input  logic [spq_pkg::PRIO_W-1:0] priority_req,
    input  logic [spq_pkg::TAG_W-1:0]  message_tag,
    input  logic                       entry_valid,
    input  logic [spq_pkg::PRIO_W-1:0] entry_priority,
    input  logic [spq_pkg::TAG_W-1:0]  entry_tag,
    input  logic [spq_pkg::STAT_W-1:0] status,
    input  logic                       is_empty,
    output int                         fail_count,
    output int                         outstanding
);
    import spq_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic [STAT_W-1:0] stat;
        logic              empty;
    } queue_outcome_t;

    logic [PRIO_W-1:0] shadow_prio [CAPACITY];
    logic [TAG_W-1:0]  shadow_tag  [CAPACITY];
    int                shadow_count;
    queue_outcome_t    outcomes [$];
    int                errors;

    assign fail_count = errors;

    // Applies one request to the shadow slots and returns its result beat.
    task automatic sorted_insert_remove(input logic kind,
                                        input logic [PRIO_W-1:0] raw_prio,
                                        input logic [TAG_W-1:0] tag,
                                        output queue_outcome_t res);
        logic [PRIO_W-1:0] p;
        int                pos;
        res = '0;
        res.stat = ST_OK;
        if (kind == REQ_INSERT)
        begin
            if (shadow_count >= CAPACITY)
            begin
                res.stat = ST_FULL;
            end
            else
            begin
                p = (raw_prio > PRIORITY_LEVELS - 1) ? PRIO_W'(PRIORITY_LEVELS - 1) : raw_prio;
                pos = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                begin
                    if (shadow_prio[i] >= p) pos = i;
                end
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_tag[i]  = shadow_tag[i-1];
                end
                shadow_prio[pos] = p;
                shadow_tag[pos]  = tag;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.stat = ST_EMPTY;
            end
            else
            begin
                res.valid = 1'b1;
                res.prio  = shadow_prio[0];
                res.tag   = shadow_tag[0];
                for (int i = 0; i + 1 < shadow_count; i++)
                begin
                    shadow_prio[i] = shadow_prio[i+1];
                    shadow_tag[i]  = shadow_tag[i+1];
                end
                shadow_count--;
            end
        end
        res.empty = (shadow_count == 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_outcome_t want;
        queue_outcome_t next;
        int             delta;
        if (!rst_n)
        begin
            shadow_count = 0;
            outcomes.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            delta = 0;
            // Results are compared before the new request is forecast, so a
            // stray beat can never match the request accepted at this edge.
            if (done)
            begin
                if (outcomes.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected, actual valid %0b",
                             $time, entry_valid);
                    $display("    prio %0h tag %0h status %0h empty %0b",
                             entry_priority, entry_tag, status, is_empty);
                end
                else
                begin
                    want = outcomes.pop_front();
                    delta--;
                    check_field("entry_valid", 32'(want.valid), 32'(entry_valid));
                    check_field("entry_priority", 32'(want.prio), 32'(entry_priority));
                    check_field("entry_tag", 32'(want.tag), 32'(entry_tag));
                    check_field("status", 32'(want.stat), 32'(status));
                    check_field("is_empty", 32'(want.empty), 32'(is_empty));
                end
            end
            if (start && !busy)
            begin
                sorted_insert_remove(req_type, priority_req, message_tag, next);
                outcomes.push_back(next);
                delta++;
            end
            outstanding <= outstanding + delta;
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: request stimulus and verdict for the sorted priority queue
// Drives a directed fill, overflow and underflow sequence, then bursts of
// random inserts and removes with shifting insert bias; the checker judges.
// ----------------------------------------------------------------------------
module tb;
    import spq_pkg::*;

    localparam int CAPACITY        = DEF_CAPACITY;
    localparam int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS;
    localparam int RANDOM_BEATS    = 2000;
    // The slowest run is about 2000 request beats plus the idle gaps between
    // bursts; the limit leaves ample room.
    localparam int CYCLE_LIMIT     = 200000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  message_tag;
    logic              entry_valid;
    logic [PRIO_W-1:0] entry_priority;
    logic [TAG_W-1:0]  entry_tag;
    logic [STAT_W-1:0] status;
    logic              is_empty;
    int                fail_count;
    int                outstanding;
    int                cycles;

    sorted_priority_queue #(
        .CAPACITY        (CAPACITY),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .req_type       (req_type),
        .priority_req   (priority_req),
        .message_tag    (message_tag),
        .entry_valid    (entry_valid),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .status         (status),
        .is_empty       (is_empty)
    );

    spq_checker #(
        .CAPACITY        (CAPACITY),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .req_type       (req_type),
        .priority_req   (priority_req),
        .message_tag    (message_tag),
        .entry_valid    (entry_valid),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .status         (status),
        .is_empty       (is_empty),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The watchdog ends a run that hangs, for example when the block stops
    // producing result beats and the drain below never completes.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Presents one request beat and holds it until the block takes it. The
    // busy flag read right after the edge is the value the block saw there,
    // because the block updates its registers later in the same time step.
    // On return start is still high, so a following beat continues the burst
    // with a single assignment to start in this step.
    task automatic send_beat(input logic kind, input logic [PRIO_W-1:0] prio,
                             input logic [TAG_W-1:0] tag);
        start        <= 1'b1;
        req_type     <= kind;
        priority_req <= prio;
        message_tag  <= tag;
        do @(posedge clk); while (busy);
    endtask

    // Drops start for a number of cycles and scribbles on the payload ports,
    // which the block must ignore while no request is presented.
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        for (int i = 0; i < n; i++)
        begin
            req_type     <= 1'($urandom);
            priority_req <= PRIO_W'($urandom);
            message_tag  <= TAG_W'($urandom);
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every forecast result beat has arrived.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        logic [PRIO_W-1:0] fill_prio [16];
        logic [TAG_W-1:0]  fill_tag  [16];
        int                sent;
        int                burst;
        int                insert_pct;
        int                segment_left;
        logic              kind;
        logic [PRIO_W-1:0] prio;

        cycles       = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_INSERT;
        priority_req = '0;
        message_tag  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        idle_cycles(2);

        // Directed part. A remove from the fresh queue must report empty.
        send_beat(REQ_REMOVE, '0, '0);

        // Fill the queue to capacity. The list mixes the lowest priority, the
        // raw value 7 that saturates to the highest level, runs of equal
        // priorities so that the newest entry must come out first, and tags
        // with all bits low and all bits high.
        fill_prio = '{3'd3, 3'd0, 3'd7, 3'd6, 3'd3, 3'd3, 3'd0, 3'd5,
                      3'd6, 3'd7, 3'd1, 3'd2, 3'd4, 3'd0, 3'd3, 3'd6};
        fill_tag  = '{16'h0000, 16'hFFFF, 16'hA5A5, 16'h5A5A, 16'h0001, 16'h8000,
                      16'h1234, 16'hFEDC, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                      16'h7FFF, 16'hC3C3, 16'h3C3C, 16'hBEEF};
        for (int i = 0; i < CAPACITY && i < 16; i++)
        begin
            send_beat(REQ_INSERT, fill_prio[i], fill_tag[i]);
        end

        // One more insert must be rejected because the queue is full.
        send_beat(REQ_INSERT, 3'd0, 16'hDEAD);

        // Take a few heads out, then hold off until all results are back.
        repeat (6) send_beat(REQ_REMOVE, PRIO_W'($urandom), TAG_W'($urandom));
        drain_results();

        // Random part. The traffic runs in segments whose insert bias swings
        // between filling, balanced and draining, so the queue keeps crossing
        // both the full and the empty boundary. Requests come in bursts of
        // random length; some gaps are zero so that long back-to-back
        // stretches occur as well.
        sent         = 0;
        segment_left = 0;
        insert_pct   = 50;
        while (sent < RANDOM_BEATS)
        begin
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_BEATS; b++)
            begin
                kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
                // A narrow priority band now and then makes ties common.
                if ($urandom_range(0, 3) == 0)
                    prio = PRIO_W'($urandom_range(2, 3));
                else
                    prio = PRIO_W'($urandom_range(0, 7));
                send_beat(kind, prio, TAG_W'($urandom));
                sent++;
                if (segment_left > 0) segment_left--;
            end
            if ($urandom_range(0, 49) == 0)
                drain_results();
            else if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end

        drain_results();
        idle_cycles(4);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
